// ===== sv/quadratic_bezier_path_flattener_assert.svh =====
`ifndef QUADRATIC_BEZIER_PATH_FLATTENER_ASSERT_SVH
`define QUADRATIC_BEZIER_PATH_FLATTENER_ASSERT_SVH

// same-cycle implication
`define QBPF_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QBPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qbpf_pkg.sv =====
package qbpf_pkg;

    localparam int QUAL_W = 8;
    localparam logic [QUAL_W-1:0] QUALITY_RESET = 8'd12;

    typedef enum logic [1:0] {
        OP_MOVE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_CURVE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic load_in;
        logic np_start;
        logic np_load;
        logic d_start;
        logic d_load;
        logic step;
        logic take;
        logic push_pend;
        logic push_last;
        logic src_end;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic coll;
        logic veq;
        logic out_free;
        logic div_done;
        logic cnt_last;
        logic np_one;
    } stat_t;

endpackage

// ===== sv/qbpf_div.sv =====
module qbpf_div #(
    parameter int NW = 50,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quot_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW-1:0] diff;
    logic          ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial[DW-1:0] - den_reg;
    assign done  = !busy_reg;
    assign quot  = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff : trial[DW-1:0];
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[NW-2:0], ge};
        end
    end

endmodule

// ===== sv/qbpf_ctrl.sv =====
module qbpf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output qbpf_pkg::cmd_t   cmd,
    input  qbpf_pkg::stat_t  stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DECIDE, S_NPDIV, S_NPSET, S_MULB, S_DSTART,
        S_DDIV, S_DSET, S_STEP, S_VCUR, S_VEND, S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: state_next = S_DECIDE;
            S_DECIDE: begin
                unique case (stat.op)
                    qbpf_pkg::OP_MOVE: begin
                        cmd.src_end = 1'b1;
                        cmd.take    = 1'b1;
                        pend_next   = 1'b1;
                        state_next  = S_FLUSH;
                    end
                    qbpf_pkg::OP_LINE: state_next = S_VEND;
                    qbpf_pkg::OP_CURVE: begin
                        if (stat.coll) begin
                            state_next = S_VEND;
                        end else begin
                            cmd.np_start = 1'b1;
                            state_next   = S_NPDIV;
                        end
                    end
                    qbpf_pkg::OP_NONE: state_next = S_IDLE;
                    default: state_next = S_IDLE;
                endcase
            end
            S_NPDIV: begin
                if (stat.div_done) begin
                    state_next = S_NPSET;
                end
            end
            S_NPSET: begin
                cmd.np_load = 1'b1;
                state_next  = S_MULB;
            end
            S_MULB: state_next = S_DSTART;
            S_DSTART: begin
                cmd.d_start = 1'b1;
                state_next  = S_DDIV;
            end
            S_DDIV: begin
                if (stat.div_done) begin
                    state_next = S_DSET;
                end
            end
            S_DSET: begin
                cmd.d_load = 1'b1;
                state_next = stat.np_one ? S_VEND : S_STEP;
            end
            S_STEP: begin
                cmd.step   = 1'b1;
                state_next = S_VCUR;
            end
            S_VCUR, S_VEND: begin
                cmd.src_end = (state_reg == S_VEND);
                if (stat.veq || !pend_reg || stat.out_free) begin
                    if (!stat.veq) begin
                        cmd.take      = 1'b1;
                        cmd.push_pend = pend_reg;
                        pend_next     = 1'b1;
                    end
                    if (state_reg == S_VEND) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next = stat.cnt_last ? S_VEND : S_STEP;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_reg) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.push_last = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== sv/qbpf_datapath.sv =====
module qbpf_datapath #(
    parameter int COORD_BITS   = 24,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qbpf_pkg::cmd_t                      cmd,
    output qbpf_pkg::stat_t                     stat,
    input  logic [1:0]                          in_op,
    input  logic signed [COORD_BITS-1:0]        in_qx,
    input  logic signed [COORD_BITS-1:0]        in_qy,
    input  logic signed [COORD_BITS-1:0]        in_ex,
    input  logic signed [COORD_BITS-1:0]        in_ey,
    input  logic                                cfg_load,
    input  logic [qbpf_pkg::QUAL_W-1:0]         cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [COORD_BITS-1:0]        out_x,
    output logic signed [COORD_BITS-1:0]        out_y,
    output logic                                out_last
);

    localparam int W    = COORD_BITS;
    localparam int NP_W = $clog2(MAX_SEGMENTS + 1);
    localparam int T_W  = W + NP_W + 2;
    localparam int NW   = W + NP_W + 19;
    localparam int AW   = NW + 2;
    localparam int LW   = W + 3;
    localparam int DW   = (2 * NP_W > 16) ? 2 * NP_W : 16;
    localparam int QW   = qbpf_pkg::QUAL_W;

    logic [1:0]              op_reg;
    logic signed [W-1:0]     qx_reg, qy_reg, ex_reg, ey_reg;
    logic signed [W-1:0]     pen_x_reg, pen_y_reg;
    logic [QW-1:0]           qual_reg;
    logic signed [2*W+1:0]   prod1_reg, prod2_reg;
    logic [LW-1:0]           len_reg;
    logic signed [W+1:0]     ax_reg, ay_reg;
    logic [NP_W-1:0]         np_reg, cnt_reg;
    logic [2*NP_W-1:0]       np2_reg;
    logic signed [T_W-1:0]   t1x_reg, t1y_reg;
    logic                    s2x_reg, s2y_reg, s1x_reg, s1y_reg;
    logic signed [AW-1:0]    d1x_reg, d1y_reg, d2x_reg, d2y_reg, accx_reg, accy_reg;
    logic                    out_valid_reg, out_last_reg;
    logic signed [W-1:0]     out_x_reg, out_y_reg;

    logic signed [W:0]       dqx, dqy, dex, dey, dxe, dye;
    logic [W:0]              m_dqx, m_dqy, m_dxe, m_dye;
    logic signed [T_W-1:0]   bnx, bny;
    logic [W+1:0]            m_ax, m_ay;
    logic [T_W-1:0]          m_t1x, m_t1y;
    logic [NW-1:0]           half;
    logic [QW-1:0]           qual_eff;
    logic [NW-1:0]           dnum [4];
    logic [DW-1:0]           dden [4];
    logic [NW-1:0]           dquot [4];
    logic [3:0]              ddone;
    logic                    dstart0;
    logic signed [AW-1:0]    rsx, rsy, rhx, rhy;
    logic                    fitx, fity;
    logic signed [W-1:0]     cvx, cvy, vx, vy;

    assign dqx = {qx_reg[W-1], qx_reg} - {pen_x_reg[W-1], pen_x_reg};
    assign dqy = {qy_reg[W-1], qy_reg} - {pen_y_reg[W-1], pen_y_reg};
    assign dex = {ex_reg[W-1], ex_reg} - {pen_x_reg[W-1], pen_x_reg};
    assign dey = {ey_reg[W-1], ey_reg} - {pen_y_reg[W-1], pen_y_reg};
    assign dxe = {ex_reg[W-1], ex_reg} - {qx_reg[W-1], qx_reg};
    assign dye = {ey_reg[W-1], ey_reg} - {qy_reg[W-1], qy_reg};
    assign m_dqx = dqx[W] ? -dqx : dqx;
    assign m_dqy = dqy[W] ? -dqy : dqy;
    assign m_dxe = dxe[W] ? -dxe : dxe;
    assign m_dye = dye[W] ? -dye : dye;

    assign bnx = dqx * $signed({1'b0, np_reg});
    assign bny = dqy * $signed({1'b0, np_reg});
    assign m_ax  = ax_reg[W+1] ? -ax_reg : ax_reg;
    assign m_ay  = ay_reg[W+1] ? -ay_reg : ay_reg;
    assign m_t1x = t1x_reg[T_W-1] ? -t1x_reg : t1x_reg;
    assign m_t1y = t1y_reg[T_W-1] ? -t1y_reg : t1y_reg;
    assign half  = NW'(np2_reg >> 1);
    assign qual_eff = (qual_reg == '0) ? QW'(1) : qual_reg;

    assign dstart0 = cmd.np_start | cmd.d_start;
    assign dnum[0] = cmd.d_start ? NW'({m_ax, 17'b0}) + half : NW'(len_reg);
    assign dden[0] = cmd.d_start ? DW'(np2_reg) : DW'({qual_eff, 8'b0});
    assign dnum[1] = NW'({m_ay, 17'b0}) + half;
    assign dden[1] = DW'(np2_reg);
    assign dnum[2] = NW'({m_t1x, 16'b0}) + half;
    assign dden[2] = DW'(np2_reg);
    assign dnum[3] = NW'({m_t1y, 16'b0}) + half;
    assign dden[3] = DW'(np2_reg);

    for (genvar i = 0; i < 4; i++) begin : g_lane
        qbpf_div #(.NW(NW), .DW(DW)) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   ((i == 0) ? dstart0 : cmd.d_start),
            .num     (dnum[i]),
            .den     (dden[i]),
            .done    (ddone[i]),
            .quot    (dquot[i])
        );
    end

    assign rsx  = accx_reg + AW'(32768);
    assign rsy  = accy_reg + AW'(32768);
    assign rhx  = rsx >>> 16;
    assign rhy  = rsy >>> 16;
    assign fitx = (&rhx[AW-1:W-1]) | ~(|rhx[AW-1:W-1]);
    assign fity = (&rhy[AW-1:W-1]) | ~(|rhy[AW-1:W-1]);
    assign cvx  = fitx ? rhx[W-1:0]
                : (rhx[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    assign cvy  = fity ? rhy[W-1:0]
                : (rhy[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    assign vx   = cmd.src_end ? ex_reg : cvx;
    assign vy   = cmd.src_end ? ey_reg : cvy;

    assign stat.op       = qbpf_pkg::op_t'(op_reg);
    assign stat.coll     = (prod1_reg == prod2_reg);
    assign stat.veq      = (vx == pen_x_reg) && (vy == pen_y_reg);
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.div_done = &ddone;
    assign stat.cnt_last = (cnt_reg == NP_W'(np_reg - 1'b1));
    assign stat.np_one   = (np_reg == NP_W'(1));

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qual_reg      <= qbpf_pkg::QUALITY_RESET;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_load) begin
                qual_reg <= cfg_data;
            end
            if (cmd.take) begin
                pen_x_reg <= vx;
                pen_y_reg <= vy;
            end
            if (cmd.push_pend || cmd.push_last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= in_op;
            qx_reg <= in_qx;
            qy_reg <= in_qy;
            ex_reg <= in_ex;
            ey_reg <= in_ey;
        end
        prod1_reg <= dqx * dey;
        prod2_reg <= dqy * dex;
        len_reg   <= LW'(m_dxe) + LW'(m_dqx) + LW'(m_dye) + LW'(m_dqy);
        ax_reg    <= {{2{pen_x_reg[W-1]}}, pen_x_reg} - {qx_reg[W-1], qx_reg, 1'b0}
                   + {{2{ex_reg[W-1]}}, ex_reg};
        ay_reg    <= {{2{pen_y_reg[W-1]}}, pen_y_reg} - {qy_reg[W-1], qy_reg, 1'b0}
                   + {{2{ey_reg[W-1]}}, ey_reg};
        t1x_reg   <= (bnx <<< 1) + ax_reg;
        t1y_reg   <= (bny <<< 1) + ay_reg;
        np2_reg   <= np_reg * np_reg;
        if (cmd.np_load) begin
            if (dquot[0] == '0) begin
                np_reg <= NP_W'(1);
            end else if (dquot[0] > NW'(MAX_SEGMENTS)) begin
                np_reg <= NP_W'(MAX_SEGMENTS);
            end else begin
                np_reg <= dquot[0][NP_W-1:0];
            end
        end
        if (cmd.d_start) begin
            s2x_reg <= ax_reg[W+1];
            s2y_reg <= ay_reg[W+1];
            s1x_reg <= t1x_reg[T_W-1];
            s1y_reg <= t1y_reg[T_W-1];
        end
        if (cmd.d_load) begin
            d2x_reg  <= s2x_reg ? -AW'(dquot[0]) : AW'(dquot[0]);
            d2y_reg  <= s2y_reg ? -AW'(dquot[1]) : AW'(dquot[1]);
            d1x_reg  <= s1x_reg ? -AW'(dquot[2]) : AW'(dquot[2]);
            d1y_reg  <= s1y_reg ? -AW'(dquot[3]) : AW'(dquot[3]);
            accx_reg <= AW'(pen_x_reg) <<< 16;
            accy_reg <= AW'(pen_y_reg) <<< 16;
            cnt_reg  <= '0;
        end else if (cmd.step) begin
            accx_reg <= accx_reg + d1x_reg;
            accy_reg <= accy_reg + d1y_reg;
            d1x_reg  <= d1x_reg + d2x_reg;
            d1y_reg  <= d1y_reg + d2y_reg;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.push_pend || cmd.push_last) begin
            out_x_reg    <= pen_x_reg;
            out_y_reg    <= pen_y_reg;
            out_last_reg <= cmd.push_last;
        end
    end

endmodule

// ===== sv/quadratic_bezier_path_flattener.sv =====
// Path flattener: takes move, line and quadratic-curve commands one at a time and returns
// deduplicated polyline vertices in Q16.8, tlast on the final vertex of each command. For a
// curve that is not collinear, the segment count and then the four forward differences each
// come from a one-bit-per-cycle restoring divider, after which the stepping loop advances the
// accumulators and emits the vertices in turn, holding while the output beat is not taken.
// quality_step is written through the cfg port, which is always ready; a value of zero acts
// as one.
`include "quadratic_bezier_path_flattener_assert.svh"

module quadratic_bezier_path_flattener #(
    parameter int COORD_BITS   = 24,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // op, ctrl_x, ctrl_y, end_x, end_y
    input  logic [((4*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // point_x, point_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [qbpf_pkg::QUAL_W-1:0] cfg_data
);

    localparam int W     = COORD_BITS;
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

    qbpf_pkg::cmd_t  cmd;
    qbpf_pkg::stat_t stat;
    logic signed [W-1:0] point_x, point_y;

    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_W'({point_y, point_x});

    qbpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    qbpf_datapath #(
        .COORD_BITS   (COORD_BITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tdata[1:0]),
        .in_qx     (s_tdata[2 +: W]),
        .in_qy     (s_tdata[2+W +: W]),
        .in_ex     (s_tdata[2+2*W +: W]),
        .in_ey     (s_tdata[2+3*W +: W]),
        .cfg_load  (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_x     (point_x),
        .out_y     (point_y),
        .out_last  (m_tlast)
    );

    `QBPF_ASSERT(a_push_free, aclk, aresetn, cmd.push_pend || cmd.push_last, stat.out_free, "beat overwritten")
    `QBPF_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken")
    `QBPF_ASSERT_NEXT(a_last_beat, aclk, aresetn, cmd.push_last, m_tvalid && m_tlast, "final beat lost")

endmodule
